FILE: rtl/core/wccs_pkg.sv
// shared types, constants and lookup functions for the windowed channel charge sum
// no dependencies
`timescale 1ns / 1ps

package wccs_pkg;

   // field widths fixed by the pulse and result formats
   localparam int CardW    = 5;
   localparam int ChanW    = 2;
   localparam int MbW      = 8;
   localparam int TimeW    = 16;
   localparam int ChargeW  = 24;
   localparam int SumW     = 32;
   localparam int CountW   = 8;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   // hit map covers every card/channel pair that fits the input fields
   localparam int MapIdxW  = CardW + ChanW;
   localparam int MapDepth = 2 ** MapIdxW;

   // hit map kept as one word of channel bits per card
   localparam int CardSlots = 2 ** CardW;
   localparam int ChanSlots = 2 ** ChanW;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrSelMinibuffer = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrWindowStart   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrWindowEnd     = 2'd2;

   // tank card list
   localparam int TankCount = 15;
   localparam logic [CardW-1:0] TankCards [TankCount] = '{
      5'd3, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10, 5'd11,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd18, 5'd19, 5'd20
   };

   // excluded card/channel pairs
   localparam int ExclCount = 4;
   localparam logic [CardW-1:0] ExclCards [ExclCount] = '{5'd4, 5'd8, 5'd14, 5'd18};
   localparam logic [ChanW-1:0] ExclChans [ExclCount] = '{2'd1, 2'd2, 2'd0, 2'd0};

   // classified pulse passed from front to back
   typedef struct packed {
      logic                 qualify;
      logic [MapIdxW-1:0]   map_idx;
      logic [ChargeW-1:0]   charge;
      logic                 last;
   } pulse_type;

   // event totals
   typedef struct packed {
      logic [SumW-1:0]      total_charge;
      logic [CountW-1:0]    hit_pmt_count;
      logic                 charge_saturated;
   } result_type;

   // card membership in the tank list
   function automatic logic card_is_tank(input logic [CardW-1:0] card);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < TankCount; i++) begin
         if (TankCards[i] == card) hit = 1'b1;
      end
      return hit;
   endfunction

   // card/channel pair on the exclusion list
   function automatic logic pair_is_excluded(input logic [CardW-1:0] card,
                                             input logic [ChanW-1:0] chan);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < ExclCount; i++) begin
         if (ExclCards[i] == card && ExclChans[i] == chan) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

FILE: rtl/core/wccs_fifo.sv
// small first-in first-out queue of registers, for pulses and results
// no package dependencies
`timescale 1ns / 1ps

module wccs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status and read port
   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/wccs_front.sv
// front stage: configuration registers and pulse classification
// depends on wccs_pkg
`timescale 1ns / 1ps

module wccs_front import wccs_pkg::*; #(
   parameter int NUM_CARDS         = 32,
   parameter int CHANNELS_PER_CARD = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   input  logic [CardW-1:0]    card_index,
   input  logic [ChanW-1:0]    channel_index,
   input  logic [MbW-1:0]      pulse_minibuffer,
   input  logic [TimeW-1:0]    start_sample,
   input  logic [ChargeW-1:0]  pulse_charge,
   input  logic                is_last,
   output pulse_type           pulse
);

   logic [MbW-1:0]   sel_mb_ff;
   logic [TimeW-1:0] win_start_ff;
   logic [TimeW-1:0] win_end_ff;
   logic             in_range;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_mb_ff    <= '0;
         win_start_ff <= '0;
         win_end_ff   <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CsrSelMinibuffer: sel_mb_ff    <= csr_data[MbW-1:0];
            CsrWindowStart:   win_start_ff <= csr_data;
            CsrWindowEnd:     win_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // card and channel inside the configured detector size
   assign in_range = (int'(card_index) < NUM_CARDS) &&
                     (int'(channel_index) < CHANNELS_PER_CARD);

   // classify the pulse
   always_comb begin
      pulse.qualify = in_range && card_is_tank(card_index) &&
                      !pair_is_excluded(card_index, channel_index) &&
                      (pulse_minibuffer == sel_mb_ff) &&
                      (start_sample >= win_start_ff) && (start_sample <= win_end_ff);
      pulse.map_idx = {card_index, channel_index};
      pulse.charge  = pulse_charge;
      pulse.last    = is_last;
   end

endmodule

FILE: rtl/core/wccs_back.sv
// back stage: charge accumulation, hit map and event totals
// depends on wccs_pkg
`timescale 1ns / 1ps

module wccs_back import wccs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pulse_valid,
   input  pulse_type  pulse,
   output logic       pulse_pop,
   input  logic       result_full,
   output logic       result_push,
   output result_type result
);

   logic [SumW-1:0]      sum_ff, sum_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 sat_ff, sat_in;
   logic [ChanSlots-1:0] hit_map_ff [CardSlots];
   logic [CardW-1:0]     hit_card;
   logic [ChanW-1:0]     hit_chan;
   logic [SumW:0]        sum_wide;
   logic                 hit_new;
   logic                 take;

   // a last item waits for room in the result queue
   assign take        = pulse_valid && !(pulse.last && result_full);
   assign pulse_pop   = take;
   assign result_push = take && pulse.last;

   // hit map word per card, one bit per channel
   assign hit_card = pulse.map_idx[MapIdxW-1:ChanW];
   assign hit_chan = pulse.map_idx[ChanW-1:0];

   assign sum_wide = {1'b0, sum_ff} + (SumW + 1)'(pulse.charge);
   assign hit_new  = pulse.qualify && !hit_map_ff[hit_card][hit_chan];

   // updated totals including the current item
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      if (pulse.qualify) begin
         if (sum_wide[SumW]) begin
            sum_in = '1;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_wide[SumW-1:0];
         end
      end
      if (hit_new && count_ff != '1) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign result.total_charge     = sum_in;
   assign result.hit_pmt_count    = count_in;
   assign result.charge_saturated = sat_in;

   // accumulators, cleared at the end of each event
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
         for (int i = 0; i < CardSlots; i++) begin
            hit_map_ff[i] <= '0;
         end
      end else if (take) begin
         if (pulse.last) begin
            sum_ff   <= '0;
            count_ff <= '0;
            sat_ff   <= 1'b0;
            for (int i = 0; i < CardSlots; i++) begin
               hit_map_ff[i] <= '0;
            end
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            sat_ff   <= sat_in;
            if (hit_new) begin
               hit_map_ff[hit_card][hit_chan] <= 1'b1;
            end
         end
      end
   end

endmodule

FILE: rtl/core/windowed_channel_charge_sum.sv
// top level of the windowed channel charge sum
// depends on wccs_pkg, wccs_front, wccs_fifo, wccs_back
`timescale 1ns / 1ps

// Usage
// - pulses enter on the req_ queue port: an item is taken at a clock edge with
//   req_push high and req_full low
// - totals leave on the rsp_ queue port: the oldest result is shown while
//   rsp_empty is low and is taken at an edge with rsp_pop high
// - csr_ready is always high; registers (minibuffer, window start, window end)
//   are written by the user over csr_ only while no event is in flight (unenforced)
// - throughput: one pulse per cycle while req_full is low, set by the add and
//   hit map lookup in the back stage
// - a last pulse is registered in the classify queue and its totals in the
//   result queue before they show on the rsp_ ports
// - when the receiver stalls, results collect in a two-entry result queue;
//   pulses keep flowing until a last pulse finds that queue full, then the
//   classify queue fills and req_full rises
// - reset clears the registers to their defaults, empties both queues and
//   clears the sum, the hit count, the saturation flag and the hit map at once
module windowed_channel_charge_sum import wccs_pkg::*; #(
   parameter int NUM_CARDS         = 32,
   parameter int CHANNELS_PER_CARD = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   input  logic                req_push,
   output logic                req_full,
   input  logic [CardW-1:0]    req_card_index,
   input  logic [ChanW-1:0]    req_channel_index,
   input  logic [MbW-1:0]      req_pulse_minibuffer,
   input  logic [TimeW-1:0]    req_pulse_time,
   input  logic [ChargeW-1:0]  req_pulse_charge,
   input  logic                req_is_last,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [SumW-1:0]     rsp_total_charge,
   output logic [CountW-1:0]   rsp_hit_pmt_count,
   output logic                rsp_charge_saturated
);

   pulse_type  front_pulse;
   pulse_type  back_pulse;
   logic       mid_empty;
   logic       mid_pop;
   logic       res_full;
   logic       res_push;
   result_type back_result;
   result_type rsp_result;

   // classification
   wccs_front #(
      .NUM_CARDS         (NUM_CARDS),
      .CHANNELS_PER_CARD (CHANNELS_PER_CARD)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .card_index       (req_card_index),
      .channel_index    (req_channel_index),
      .pulse_minibuffer (req_pulse_minibuffer),
      .start_sample     (req_pulse_time),
      .pulse_charge     (req_pulse_charge),
      .is_last          (req_is_last),
      .pulse            (front_pulse)
   );

   // queue between classification and accumulation
   wccs_fifo #(
      .WIDTH ($bits(pulse_type)),
      .DEPTH (2)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_pulse),
      .full    (req_full),
      .pop     (mid_pop),
      .rd_data (back_pulse),
      .empty   (mid_empty)
   );

   // accumulation
   wccs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pulse_valid (!mid_empty),
      .pulse       (back_pulse),
      .pulse_pop   (mid_pop),
      .result_full (res_full),
      .result_push (res_push),
      .result      (back_result)
   );

   // result queue
   wccs_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (back_result),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_result),
      .empty   (rsp_empty)
   );

   assign rsp_total_charge     = rsp_result.total_charge;
   assign rsp_hit_pmt_count    = rsp_result.hit_pmt_count;
   assign rsp_charge_saturated = rsp_result.charge_saturated;

endmodule
